>>> rtl/etc1_pkg.sv
// ----------------------------------------------------------------------------
// etc1_pkg
// Shared types and constants for the ETC1 block decoder: configuration
// register indexes, the decoded block record and the modifier table.
// ----------------------------------------------------------------------------
package etc1_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_OUTPUT_MODE  = 2'd2;

	// output packing modes
	localparam logic MODE_RGB888 = 1'b0;
	localparam logic MODE_RGB565 = 1'b1;

	// decoded block, handed from the front end to the back end
	typedef struct packed {
		logic [1:0][2:0][7:0] colour;   // [subblock][channel r,g,b]
		logic [2:0]           tbl_a;
		logic [2:0]           tbl_b;
		logic                 flip;
		logic [31:0]          sel_bits;
		logic [15:0]          keep;     // kept pixels, row-major
		logic [15:0]          org_x;
		logic [15:0]          org_y;
	} etc1_blk_t;

	// modifier table lookup
	function automatic logic signed [8:0] etc1_modifier(input logic [2:0] tbl,
			input logic [1:0] sel);
		logic [7:0] small_m;
		logic [7:0] large_m;
		logic [8:0] mag;
		small_m = 8'd0;
		large_m = 8'd0;
		unique case (tbl)
			3'd0: begin small_m = 8'd2;  large_m = 8'd8;   end
			3'd1: begin small_m = 8'd5;  large_m = 8'd17;  end
			3'd2: begin small_m = 8'd9;  large_m = 8'd29;  end
			3'd3: begin small_m = 8'd13; large_m = 8'd42;  end
			3'd4: begin small_m = 8'd18; large_m = 8'd60;  end
			3'd5: begin small_m = 8'd24; large_m = 8'd80;  end
			3'd6: begin small_m = 8'd33; large_m = 8'd106; end
			default: begin small_m = 8'd47; large_m = 8'd183; end
		endcase
		mag = {1'b0, (sel[0] ? large_m : small_m)};
		return sel[1] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

>>> rtl/etc1_block_decoder.sv
// ----------------------------------------------------------------------------
// etc1_block_decoder
// ETC1 texture block decoder with raster placement and edge clipping.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one 64-bit ETC1 block; the block yields
// up to 16 pixels, one per output transfer, in row-major order with
// block_last on the final kept pixel. The back end walks all 16 pixel
// positions at one per cycle while the output is not stalled, clipped
// positions included, and the front end keeps accepting blocks into a short
// queue meanwhile, so the back end can load the next block while it walks
// the last position of the current one. Fully clipped blocks never enter the
// queue. Configuration writes take effect at once and are meant to be made
// while the decoder is idle; they leave the block counters alone.
// ----------------------------------------------------------------------------
module etc1_block_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// block input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] block_word_high,
	input  logic [31:0] block_word_low,
	// pixel output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [23:0] pixel_data,
	output logic        block_last
);
	import etc1_pkg::*;

	logic [15:0] image_width_q;
	logic [15:0] image_height_q;
	logic        output_mode_q;
	logic        push;
	logic        queue_full;
	logic        queue_empty;
	logic        pop;
	etc1_blk_t   push_data;
	etc1_blk_t   queue_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 16'd4;
			image_height_q <= 16'd4;
			output_mode_q  <= MODE_RGB888;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_OUTPUT_MODE:  output_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	etc1_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.block_word_high (block_word_high),
		.block_word_low  (block_word_low),
		.image_width     (image_width_q),
		.image_height    (image_height_q),
		.queue_full      (queue_full),
		.push            (push),
		.push_data       (push_data)
	);

	etc1_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.pop_data  (queue_data)
	);

	etc1_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.output_mode (output_mode_q),
		.queue_empty (queue_empty),
		.queue_data  (queue_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_data  (pixel_data),
		.block_last  (block_last)
	);

endmodule

>>> rtl/etc1_front.sv
// ----------------------------------------------------------------------------
// etc1_front
// Accepts blocks, expands the base colours, works out the kept-pixel mask
// from the block position and image size, and steps the block counters.
// ----------------------------------------------------------------------------
module etc1_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         block_word_high,
	input  logic [31:0]         block_word_low,
	input  logic [15:0]         image_width,
	input  logic [15:0]         image_height,
	input  logic                queue_full,
	output logic                push,
	output etc1_pkg::etc1_blk_t push_data
);
	import etc1_pkg::*;

	logic [13:0] col_q;
	logic [13:0] row_q;
	logic        accept;
	logic        diff;
	logic [15:0] org_x;
	logic [15:0] org_y;
	logic [15:0] keep;
	logic [3:0]  x_ok;
	logic [3:0]  y_ok;
	logic [14:0] blocks_w;
	logic [14:0] blocks_h;
	logic [13:0] col_inc;
	logic [13:0] row_inc;
	logic [1:0][2:0][7:0] colour;

	assign in_stall = queue_full;
	assign accept   = in_valid & ~queue_full;
	assign diff     = block_word_high[1];

	// base colour expansion, individual or differential
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [4:0] base5;
			logic [2:0] dlt;
			logic [4:0] sum5;
			logic [3:0] ca;
			logic [3:0] cb;
			base5 = block_word_high[27 - 8 * c +: 5];
			dlt   = block_word_high[24 - 8 * c +: 3];
			sum5  = base5 + {{2{dlt[2]}}, dlt};
			ca    = block_word_high[28 - 8 * c +: 4];
			cb    = block_word_high[24 - 8 * c +: 4];
			if (diff) begin
				colour[0][c] = {base5, base5[4:2]};
				colour[1][c] = {sum5, sum5[4:2]};
			end else begin
				colour[0][c] = {ca, ca};
				colour[1][c] = {cb, cb};
			end
		end
	end

	// clip mask against the image size
	assign org_x = {col_q, 2'b00};
	assign org_y = {row_q, 2'b00};
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			x_ok[i] = ({1'b0, org_x} + 17'(i)) < {1'b0, image_width};
			y_ok[i] = ({1'b0, org_y} + 17'(i)) < {1'b0, image_height};
		end
		for (int py = 0; py < 4; py++) begin
			for (int px = 0; px < 4; px++) begin
				keep[py * 4 + px] = x_ok[px] & y_ok[py];
			end
		end
	end

	assign push = accept & (|keep);
	always_comb begin
		push_data.colour   = colour;
		push_data.tbl_a    = block_word_high[7:5];
		push_data.tbl_b    = block_word_high[4:2];
		push_data.flip     = block_word_high[0];
		push_data.sel_bits = block_word_low;
		push_data.keep     = keep;
		push_data.org_x    = org_x;
		push_data.org_y    = org_y;
	end

	// block counters, a zero dimension counts as one block
	assign blocks_w = (image_width  == 16'd0) ? 15'd1 : 15'(({1'b0, image_width}  + 17'd3) >> 2);
	assign blocks_h = (image_height == 16'd0) ? 15'd1 : 15'(({1'b0, image_height} + 17'd3) >> 2);
	assign col_inc  = col_q + 14'd1;
	assign row_inc  = row_q + 14'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if ({1'b0, col_inc} >= blocks_w) begin
				col_q <= '0;
				row_q <= ({1'b0, row_inc} >= blocks_h) ? 14'd0 : row_inc;
			end else begin
				col_q <= col_inc;
			end
		end
	end

endmodule

>>> rtl/etc1_queue.sv
// ----------------------------------------------------------------------------
// etc1_queue
// Short first-in first-out queue of decoded blocks between front and back.
// ----------------------------------------------------------------------------
module etc1_queue #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  etc1_pkg::etc1_blk_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output etc1_pkg::etc1_blk_t pop_data
);
	import etc1_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	etc1_blk_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/etc1_back.sv
// ----------------------------------------------------------------------------
// etc1_back
// Walks the 16 pixels of a decoded block one per cycle unless stalled, applies
// the modifier with clamping, packs the colour and drives the output register.
// ----------------------------------------------------------------------------
module etc1_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                output_mode,
	input  logic                queue_empty,
	input  etc1_pkg::etc1_blk_t queue_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         pixel_x,
	output logic [15:0]         pixel_y,
	output logic [23:0]         pixel_data,
	output logic                block_last
);
	import etc1_pkg::*;

	etc1_blk_t   cur_q;
	logic        busy_q;
	logic [3:0]  idx_q;
	logic        out_valid_q;
	logic [15:0] pixel_x_q;
	logic [15:0] pixel_y_q;
	logic [23:0] pixel_data_q;
	logic        block_last_q;

	logic        out_free;
	logic        advance;
	logic        load;
	logic [1:0]  px;
	logic [1:0]  py;
	logic [3:0]  k;
	logic [1:0]  sel;
	logic        sub;
	logic signed [8:0] dmod;
	logic [2:0][7:0]   rgb;
	logic [15:0] above;
	logic        last;
	logic [23:0] packed_pix;

	function automatic logic [7:0] clamp8(input logic [7:0] c, input logic signed [8:0] d);
		logic signed [9:0] s;
		s = $signed({2'b00, c}) + 10'(d);
		if (s < 0) begin
			return 8'd0;
		end else if (s > 10'sd255) begin
			return 8'd255;
		end
		return s[7:0];
	endfunction

	assign out_free = ~out_valid_q | ~out_stall;
	assign advance  = busy_q & out_free;
	assign load     = (~busy_q | (advance & (idx_q == 4'd15))) & ~queue_empty;
	assign pop      = load;

	// per-pixel colour
	assign px   = idx_q[1:0];
	assign py   = idx_q[3:2];
	assign k    = {px, py};
	assign sel  = {cur_q.sel_bits[16 + k], cur_q.sel_bits[k]};
	assign sub  = cur_q.flip ? py[1] : px[1];
	assign dmod = etc1_modifier(sub ? cur_q.tbl_b : cur_q.tbl_a, sel);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rgb[c] = clamp8(cur_q.colour[sub][c], dmod);
		end
		for (int i = 0; i < 16; i++) begin
			above[i] = cur_q.keep[i] & (4'(i) > idx_q);
		end
	end

	assign last = ~(|above);

	always_comb begin
		unique case (output_mode)
			MODE_RGB565: packed_pix = {8'd0, rgb[0][7:3], rgb[1][7:2], rgb[2][7:3]};
			default:     packed_pix = {rgb[0], rgb[1], rgb[2]};
		endcase
	end

	// current block and pixel index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (advance) begin
			if (idx_q == 4'd15) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= queue_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance & cur_q.keep[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cur_q.keep[idx_q]) begin
			pixel_x_q    <= cur_q.org_x + 16'(px);
			pixel_y_q    <= cur_q.org_y + 16'(py);
			pixel_data_q <= packed_pix;
			block_last_q <= last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign pixel_data = pixel_data_q;
	assign block_last = block_last_q;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// ETC1 block decoder testbench
// Sends ETC1 blocks over a valid/stall channel with random idle gaps and
// random back-pressure on the pixel channel. Each accepted block is decoded
// locally, clipped against the current image size and placed with running
// block counters. The emitted pixels are checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import etc1_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_REPORTS = 10;
	// index past the end of the register list, must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [23:0] data;
		logic        last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = REG_IMAGE_WIDTH;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] block_word_high = 32'd0;
	logic [31:0] block_word_low = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [23:0] pixel_data;
	logic        block_last;

	// local copy of the decoder registers and placement counters
	logic [15:0] width_cfg = 16'd4;
	logic [15:0] height_cfg = 16'd4;
	logic        mode_cfg = MODE_RGB888;
	int          blk_col = 0;
	int          blk_row = 0;

	logic [63:0] blocks_waiting[$];
	pixel_t      pixels_due[$];
	pixel_t      got_pixel;
	pixel_t      want_pixel;
	logic [63:0] next_blk;
	logic        in_taken = 1'b0;
	int          in_gap = 0;
	int          in_calm = 0;
	int          out_hold = 0;
	int          out_calm = 0;
	int          quiet_cycles = 0;
	int          blocks_queued = 0;
	int          blocks_sent = 0;
	int          clipped_blocks = 0;
	int          pixels_checked = 0;
	int          mismatches = 0;
	int          reg_writes = 0;
	int          settings_used = 1;

	etc1_block_decoder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.block_word_high (block_word_high),
		.block_word_low  (block_word_low),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.pixel_data      (pixel_data),
		.block_last      (block_last)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// modifier magnitude from the table, sign from the high selector bit
	function automatic int modifier(input logic [2:0] tbl, input logic [1:0] sel);
		int mag;
		case (tbl)
			3'd0: mag = sel[0] ? 8 : 2;
			3'd1: mag = sel[0] ? 17 : 5;
			3'd2: mag = sel[0] ? 29 : 9;
			3'd3: mag = sel[0] ? 42 : 13;
			3'd4: mag = sel[0] ? 60 : 18;
			3'd5: mag = sel[0] ? 80 : 24;
			3'd6: mag = sel[0] ? 106 : 33;
			default: mag = sel[0] ? 183 : 47;
		endcase
		return sel[1] ? -mag : mag;
	endfunction

	function automatic int clamp_byte(input int v);
		if (v < 0)
			return 0;
		if (v > 255)
			return 255;
		return v;
	endfunction

	// image size in blocks, a zero size still counts as one block
	function automatic int span_blocks(input logic [15:0] pixels);
		int n;
		n = (int'(pixels) + 3) >> 2;
		return (n == 0) ? 1 : n;
	endfunction

	// decode one block, queue its kept pixels, advance the placement counters
	task automatic decode_block(input logic [31:0] hi, input logic [31:0] lo);
		logic [7:0]  base[2][3];
		logic [4:0]  b5;
		logic [4:0]  d5;
		logic [2:0]  d3;
		logic [3:0]  n4;
		logic [1:0]  sel;
		logic [2:0]  tbl;
		logic [23:0] word;
		int          chan[3];
		pixel_t      kept[$];
		int          ch, px, py, k, sub, m, x, y;
		for (ch = 0; ch < 3; ch++) begin
			if (hi[1]) begin
				// differential: 5-bit base, 3-bit signed delta wrapping mod 32
				b5 = hi[27 - 8 * ch +: 5];
				d3 = hi[24 - 8 * ch +: 3];
				d5 = b5 + {{2{d3[2]}}, d3};
				base[0][ch] = {b5, b5[4:2]};
				base[1][ch] = {d5, d5[4:2]};
			end else begin
				n4 = hi[28 - 8 * ch +: 4];
				base[0][ch] = {n4, n4};
				n4 = hi[24 - 8 * ch +: 4];
				base[1][ch] = {n4, n4};
			end
		end
		for (py = 0; py < 4; py++) begin
			for (px = 0; px < 4; px++) begin
				k = py + 4 * px;
				sel = {lo[k + 16], lo[k]};
				sub = hi[0] ? (py >> 1) : (px >> 1);
				tbl = (sub != 0) ? hi[4:2] : hi[7:5];
				m = modifier(tbl, sel);
				for (ch = 0; ch < 3; ch++)
					chan[ch] = clamp_byte(int'(base[sub][ch]) + m);
				if (mode_cfg == MODE_RGB565)
					word = {8'd0, chan[0][7:3], chan[1][7:2], chan[2][7:3]};
				else
					word = {chan[0][7:0], chan[1][7:0], chan[2][7:0]};
				x = blk_col * 4 + px;
				y = blk_row * 4 + py;
				if (x < int'(width_cfg) && y < int'(height_cfg))
					kept.push_back('{x[15:0], y[15:0], word, 1'b0});
			end
		end
		if (kept.size() > 0) begin
			kept[kept.size() - 1].last = 1'b1;
			foreach (kept[i])
				pixels_due.push_back(kept[i]);
		end else begin
			clipped_blocks++;
		end
		// raster advance of the block counters
		blk_col = (blk_col + 1) & 16'h3fff;
		if (blk_col >= span_blocks(width_cfg)) begin
			blk_col = 0;
			blk_row = (blk_row + 1) & 16'h3fff;
			if (blk_row >= span_blocks(height_cfg))
				blk_row = 0;
		end
	endtask

	// idle length: mostly none or short, a few long, with calm stretches
	function automatic int idle_gap(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [63:0] random_block();
		logic [31:0] hi;
		logic [31:0] lo;
		hi = $urandom;
		lo = $urandom;
		case ($urandom_range(0, 4))
			0: hi[31:8] = {3{($urandom_range(0, 1) != 0) ? 8'hff : 8'h00}};
			1: hi[7:2] = 6'h3f;
			default: ;
		endcase
		return {hi, lo};
	endfunction

	// block transfer: predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				decode_block(block_word_high, block_word_low);
				blocks_sent++;
			end
		end
	end

	// block driver, changes inputs on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (blocks_waiting.size() > 0) begin
				next_blk = blocks_waiting.pop_front();
				block_word_high <= next_blk[63:32];
				block_word_low <= next_blk[31:0];
				in_valid <= 1'b1;
				in_gap = idle_gap(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// random back-pressure on the pixel channel
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
			out_hold = idle_gap(out_calm);
		end
	end

	// pixel monitor: compare each transfer with the oldest predicted pixel
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_pixel = '{pixel_x, pixel_y, pixel_data, block_last};
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected pixel: x=%0d y=%0d data=%06h last=%0b",
						got_pixel.x, got_pixel.y, got_pixel.data, got_pixel.last);
			end else begin
				want_pixel = pixels_due.pop_front();
				pixels_checked++;
				if (got_pixel.x !== want_pixel.x || got_pixel.y !== want_pixel.y ||
						got_pixel.data !== want_pixel.data ||
						got_pixel.last !== want_pixel.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("pixel mismatch: expected x=%0d y=%0d data=%06h last=%0b, got x=%0d y=%0d data=%06h last=%0b",
							want_pixel.x, want_pixel.y, want_pixel.data, want_pixel.last,
							got_pixel.x, got_pixel.y, got_pixel.data, got_pixel.last);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic queue_block(input logic [31:0] hi, input logic [31:0] lo);
		blocks_waiting.push_back({hi, lo});
		blocks_queued++;
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			blocks_waiting.push_back(random_block());
		blocks_queued += count;
	endtask

	// wait until every block is taken and every pixel has come out
	task automatic settle();
		while (blocks_sent != blocks_queued || pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: width_cfg = value;
			REG_IMAGE_HEIGHT: height_cfg = value;
			REG_OUTPUT_MODE: mode_cfg = value[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic mode);
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_OUTPUT_MODE, {15'd0, mode});
		settings_used++;
	endtask

	// stimulus sequence
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset size 4x4, RGB888: every mode, flip, clamp and delta wrap
		queue_block(32'h0000_0000, 32'h0000_0000);
		queue_block(32'hffff_ffff, 32'hffff_ffff);
		queue_block(32'hffff_fffd, 32'h0000_ffff);
		queue_block(32'h0000_00fc, 32'hffff_0000);
		queue_block(32'hfb04_8076, 32'h5a5a_c3c3);
		queue_block(32'hfb04_8077, 32'ha5a5_3c3c);
		queue_block(32'haaaa_aaa8, 32'h5555_aaaa);
		queue_block(32'h5555_5556, 32'haaaa_5555);

		// right and bottom edge clipping in RGB565
		configure(16'd6, 16'd5, MODE_RGB565);
		queue_random(4);

		// zero width: counters run, nothing is emitted
		configure(16'd0, 16'd4, MODE_RGB888);
		queue_random(2);

		// shrink the width while the column counter is past the new edge
		configure(16'd64, 16'd64, MODE_RGB888);
		queue_random(5);
		settle();
		write_reg(REG_IMAGE_WIDTH, 16'd8);
		write_reg(REG_UNUSED, 16'hffff);
		queue_random(2);

		// largest and smallest image sizes
		configure(16'd65535, 16'd65535, MODE_RGB565);
		queue_random(2);
		configure(16'd1, 16'd1, MODE_RGB888);
		queue_random(2);

		// random blocks over several image settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				2: configure(16'd65535, 16'($urandom_range(1, 12)), MODE_RGB888);
				4: configure(16'($urandom_range(1, 12)), 16'd65535, MODE_RGB565);
				default: configure(16'($urandom_range(1, 24)), 16'($urandom_range(1, 24)),
					logic'($urandom_range(0, 1)));
			endcase
			queue_random(21);
		end

		settle();
		$display("summary: %0d blocks decoded, %0d fully clipped, %0d pixels checked",
			blocks_sent, clipped_blocks, pixels_checked);
		$display("summary: %0d register writes over %0d image settings, both packings",
			reg_writes, settings_used);
		if (mismatches == 0 && pixels_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d pixels never emitted", mismatches, pixels_due.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
